// File: rtl/core/wbl_pkg.sv
// Package with the constants, command codes and sine table of the LED encoder.
`timescale 1ns / 1ps

package wbl_pkg;

	localparam int LED_COUNT    = 2;
	localparam int BITS_PER_LED = 24;
	localparam int FRAME_BITS   = LED_COUNT * BITS_PER_LED;
	localparam int SLOT_W       = 12;
	localparam int CFG_INDEX_W  = 8;
	localparam int CFG_DATA_W   = 16;

	localparam logic [SLOT_W-1:0] FRAME_BITS_W = SLOT_W'(FRAME_BITS);

	localparam logic [15:0] ONE_CODE_RST   = 16'd75;
	localparam logic [15:0] ZERO_CODE_RST  = 16'd35;
	localparam logic [7:0]  RESET_SLOT_RST = 8'd100;
	localparam logic [15:0] INTERVAL_RST   = 16'd40;
	localparam logic [23:0] GREEN_RGB      = 24'h00FF00;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_SLOT    = 3'd1,
		CMD_SET     = 3'd2,
		CMD_BREATHE = 3'd3,
		CMD_STOP    = 3'd4
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ONE_CODE   = 8'd0,
		REG_ZERO_CODE  = 8'd1,
		REG_RESET_SLOT = 8'd2,
		REG_INTERVAL   = 8'd3
	} reg_index_t;

	function automatic logic [7:0] sine_lookup(input logic [5:0] idx);
		logic [7:0] rom [64];
		rom = '{
			8'd128, 8'd140, 8'd153, 8'd165, 8'd177, 8'd188, 8'd199, 8'd209,
			8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
			8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226, 8'd218,
			8'd209, 8'd199, 8'd188, 8'd177, 8'd165, 8'd153, 8'd140, 8'd128,
			8'd128, 8'd116, 8'd103, 8'd91,  8'd79,  8'd68,  8'd57,  8'd47,
			8'd38,  8'd30,  8'd22,  8'd16,  8'd11,  8'd6,   8'd3,   8'd2,
			8'd2,   8'd3,   8'd6,   8'd11,  8'd16,  8'd22,  8'd30,  8'd38,
			8'd47,  8'd57,  8'd68,  8'd79,  8'd91,  8'd103, 8'd116, 8'd128
		};
		return rom[idx];
	endfunction

endpackage

// File: rtl/core/ws2812_breathing_led_encoder_core.sv
// WS2812 bitstream encoder with breathing effect, single registered stage.
// The result of an accepted request is written to the output register at the next clock edge.
// Throughput: one request per cycle while out_ready is high; the output register frees itself as it is taken.
// A request is accepted whenever the output register is empty or being read.
// Reset clears control state, loads default configuration and the green color,
// and marks one frame pending; the configuration port is always ready.
`timescale 1ns / 1ps

module ws2812_breathing_led_encoder_core
	import wbl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0]             cmd,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [15:0]            compare_value,
	output logic                   accepted,
	output logic                   frame_last,
	output logic                   busy_res,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [15:0]       one_code_q, zero_code_q, interval_q;
	logic [7:0]        reset_slots_q;
	logic [23:0]       shown_color_q, breathe_color_q, frame_color_q;
	logic [SLOT_W-1:0] slot_index_q;
	logic [4:0]        bit_k_q;
	logic              running_q, pending_q, breathing_q;
	logic [5:0]        step_q;
	logic [15:0]       countdown_q;

	logic [23:0]       shown_color_d, breathe_color_d, frame_color_d;
	logic [SLOT_W-1:0] slot_index_d;
	logic [4:0]        bit_k_d;
	logic              running_d, pending_d, breathing_d;
	logic [5:0]        step_d;
	logic [15:0]       countdown_d;
	logic [15:0]       cmp_d;
	logic              acc_d, last_d;

	logic              out_valid_q;
	logic [15:0]       compare_value_q;
	logic              accepted_q, frame_last_q, busy_res_q;

	logic              in_fire;
	logic [7:0]        bright;
	logic [23:0]       scaled;
	logic [SLOT_W:0]   frame_len;
	logic [SLOT_W:0]   slot_next;
	logic [23:0]       fc;
	logic [SLOT_W-1:0] idx;
	logic [4:0]        k;
	logic [7:0]        chan;
	logic              data_bit;
	logic              start_slot;

	function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] b);
		logic [15:0] p;
		logic [16:0] t;
		p = 16'(c) * 16'(b);
		t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign bright = sine_lookup(step_q);
	assign scaled = {scale8(breathe_color_q[23:16], bright),
		scale8(breathe_color_q[15:8], bright), scale8(breathe_color_q[7:0], bright)};

	assign frame_len  = {1'b0, FRAME_BITS_W} + {{(SLOT_W-7){1'b0}}, reset_slots_q};
	assign start_slot = !running_q && pending_q;
	assign idx        = start_slot ? '0 : slot_index_q;
	assign k          = start_slot ? '0 : bit_k_q;
	assign fc         = start_slot ? shown_color_q : frame_color_q;
	assign slot_next  = {1'b0, idx} + 1'b1;

	always_comb begin
		if (k < 5'd8) begin
			chan = fc[15:8];
		end else if (k < 5'd16) begin
			chan = fc[23:16];
		end else begin
			chan = fc[7:0];
		end
	end

	assign data_bit = chan[3'd7 - k[2:0]];

	always_comb begin
		shown_color_d   = shown_color_q;
		breathe_color_d = breathe_color_q;
		frame_color_d   = frame_color_q;
		slot_index_d    = slot_index_q;
		bit_k_d         = bit_k_q;
		running_d       = running_q;
		pending_d       = pending_q;
		breathing_d     = breathing_q;
		step_d          = step_q;
		countdown_d     = countdown_q;
		cmp_d           = '0;
		acc_d           = 1'b0;
		last_d          = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (breathing_q) begin
					if (countdown_q <= 16'd1) begin
						if (scaled != shown_color_q) begin
							shown_color_d = scaled;
							pending_d     = 1'b1;
						end
						step_d      = step_q + 6'd1;
						countdown_d = interval_q;
					end else begin
						countdown_d = countdown_q - 16'd1;
					end
				end
			end
			CMD_SLOT: begin
				if (start_slot) begin
					pending_d     = 1'b0;
					frame_color_d = shown_color_q;
				end
				if (running_q || pending_q) begin
					if (idx < FRAME_BITS_W) begin
						cmp_d = data_bit ? one_code_q : zero_code_q;
					end
					if (slot_next >= frame_len) begin
						last_d       = 1'b1;
						running_d    = 1'b0;
						slot_index_d = '0;
						bit_k_d      = '0;
					end else begin
						running_d    = 1'b1;
						slot_index_d = slot_next[SLOT_W-1:0];
						bit_k_d      = (k == 5'(BITS_PER_LED - 1)) ? 5'd0 : k + 5'd1;
					end
				end
			end
			CMD_SET: begin
				if (!breathing_q) begin
					shown_color_d = {red, green, blue};
					frame_color_d = {red, green, blue};
					running_d     = 1'b1;
					pending_d     = 1'b0;
					slot_index_d  = '0;
					bit_k_d       = '0;
					acc_d         = 1'b1;
				end
			end
			CMD_BREATHE: begin
				if (!breathing_q) begin
					breathe_color_d = {red, green, blue};
					step_d          = '0;
					countdown_d     = interval_q;
					breathing_d     = 1'b1;
				end
			end
			CMD_STOP: begin
				breathing_d   = 1'b0;
				shown_color_d = '0;
				frame_color_d = '0;
				running_d     = 1'b1;
				pending_d     = 1'b0;
				slot_index_d  = '0;
				bit_k_d       = '0;
				acc_d         = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_code_q    <= ONE_CODE_RST;
			zero_code_q   <= ZERO_CODE_RST;
			reset_slots_q <= RESET_SLOT_RST;
			interval_q    <= INTERVAL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ONE_CODE:   one_code_q    <= cfg_data;
				REG_ZERO_CODE:  zero_code_q   <= cfg_data;
				REG_RESET_SLOT: reset_slots_q <= cfg_data[7:0];
				REG_INTERVAL:   interval_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_color_q   <= GREEN_RGB;
			breathe_color_q <= '0;
			frame_color_q   <= '0;
			slot_index_q    <= '0;
			bit_k_q         <= '0;
			running_q       <= 1'b0;
			pending_q       <= 1'b1;
			breathing_q     <= 1'b0;
			step_q          <= '0;
			countdown_q     <= '0;
		end else if (in_fire) begin
			shown_color_q   <= shown_color_d;
			breathe_color_q <= breathe_color_d;
			frame_color_q   <= frame_color_d;
			slot_index_q    <= slot_index_d;
			bit_k_q         <= bit_k_d;
			running_q       <= running_d;
			pending_q       <= pending_d;
			breathing_q     <= breathing_d;
			step_q          <= step_d;
			countdown_q     <= countdown_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			compare_value_q <= cmp_d;
			accepted_q      <= acc_d;
			frame_last_q    <= last_d;
			busy_res_q      <= running_d || pending_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign compare_value = compare_value_q;
	assign accepted      = accepted_q;
	assign frame_last    = frame_last_q;
	assign busy_res      = busy_res_q;

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !in_ready)
		else $error("request accepted while result stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted request produced no result");

	a_bit_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_k_q < 5'(BITS_PER_LED))
		else $error("bit position out of range");

	a_stop_starts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == CMD_STOP |=> !breathing_q && running_q && frame_color_q == '0)
		else $error("stop did not start a black frame");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_d |=> !running_q && slot_index_q == '0)
		else $error("final slot left the frame running");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the WS2812 breathing LED encoder core.
`timescale 1ns / 1ps

module testbench;
	import wbl_pkg::*;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} led_request_t;

	typedef struct packed {
		logic [15:0] compare;
		logic        accept;
		logic        last;
		logic        busy;
	} led_reply_t;

	localparam logic [7:0] BRIGHTNESS_CURVE [64] = '{
		8'd128, 8'd140, 8'd153, 8'd165, 8'd177, 8'd188, 8'd199, 8'd209,
		8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
		8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226, 8'd218,
		8'd209, 8'd199, 8'd188, 8'd177, 8'd165, 8'd153, 8'd140, 8'd128,
		8'd128, 8'd116, 8'd103, 8'd91,  8'd79,  8'd68,  8'd57,  8'd47,
		8'd38,  8'd30,  8'd22,  8'd16,  8'd11,  8'd6,   8'd3,   8'd2,
		8'd2,   8'd3,   8'd6,   8'd11,  8'd16,  8'd22,  8'd30,  8'd38,
		8'd47,  8'd57,  8'd68,  8'd79,  8'd91,  8'd103, 8'd116, 8'd128
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [2:0]             cmd = '0;
	logic [7:0]             red = '0;
	logic [7:0]             green = '0;
	logic [7:0]             blue = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [15:0]            compare_value;
	logic                   accepted;
	logic                   frame_last;
	logic                   busy_res;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	led_request_t request_queue[$];
	led_reply_t   awaited_replies[$];
	int           errors = 0;
	bit           steady = 1'b0;

	// Shadow copy of the encoder registers and state.
	logic [15:0] mark_one = ONE_CODE_RST;
	logic [15:0] mark_zero = ZERO_CODE_RST;
	logic [7:0]  gap_slots = RESET_SLOT_RST;
	logic [15:0] step_ticks = INTERVAL_RST;
	logic [23:0] shown_rgb = GREEN_RGB;
	logic [23:0] target_rgb = '0;
	logic [23:0] latched_rgb = '0;
	logic [11:0] slot_pos = '0;
	logic [15:0] ticks_left = '0;
	logic [5:0]  curve_pos = '0;
	bit          running = 1'b0;
	bit          frame_queued = 1'b1;
	bit          breathing_on = 1'b0;

	ws2812_breathing_led_encoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.compare_value(compare_value),
		.accepted(accepted),
		.frame_last(frame_last),
		.busy_res(busy_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] dim_channel(logic [7:0] c, logic [7:0] level);
		return 8'((int'(c) * int'(level)) / 255);
	endfunction

	function automatic void launch_frame();
		running = 1'b1;
		frame_queued = 1'b0;
		slot_pos = '0;
		latched_rgb = shown_rgb;
	endfunction

	function automatic led_reply_t compute_encoder_reply(led_request_t rq);
		led_reply_t  rp;
		logic [23:0] dimmed;
		logic [7:0]  level;
		logic [7:0]  chan;
		int          k;
		rp = '0;
		case (rq.op)
			CMD_TICK: begin
				if (breathing_on) begin
					if (ticks_left <= 16'd1) begin
						level = BRIGHTNESS_CURVE[curve_pos];
						dimmed = {dim_channel(target_rgb[23:16], level),
							dim_channel(target_rgb[15:8], level),
							dim_channel(target_rgb[7:0], level)};
						if (dimmed != shown_rgb) begin
							shown_rgb = dimmed;
							frame_queued = 1'b1;
						end
						curve_pos = curve_pos + 6'd1;
						ticks_left = step_ticks;
					end else begin
						ticks_left = ticks_left - 16'd1;
					end
				end
			end
			CMD_SLOT: begin
				if (!running && frame_queued)
					launch_frame();
				if (running) begin
					if (int'(slot_pos) < FRAME_BITS) begin
						k = int'(slot_pos) % BITS_PER_LED;
						if (k < 8)
							chan = latched_rgb[15:8];
						else if (k < 16)
							chan = latched_rgb[23:16];
						else
							chan = latched_rgb[7:0];
						rp.compare = chan[7 - (k % 8)] ? mark_one : mark_zero;
					end
					if (int'(slot_pos) + 1 >= FRAME_BITS + int'(gap_slots)) begin
						rp.last = 1'b1;
						running = 1'b0;
						slot_pos = '0;
					end else begin
						slot_pos = slot_pos + 12'd1;
					end
				end
			end
			CMD_SET: begin
				if (!breathing_on) begin
					shown_rgb = {rq.r, rq.g, rq.b};
					launch_frame();
					rp.accept = 1'b1;
				end
			end
			CMD_BREATHE: begin
				if (!breathing_on) begin
					target_rgb = {rq.r, rq.g, rq.b};
					curve_pos = '0;
					ticks_left = step_ticks;
					breathing_on = 1'b1;
				end
			end
			CMD_STOP: begin
				breathing_on = 1'b0;
				shown_rgb = '0;
				launch_frame();
				rp.accept = 1'b1;
			end
			default: ;
		endcase
		rp.busy = running || frame_queued;
		return rp;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : drive_requests
		led_request_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready)
				awaited_replies.push_back(compute_encoder_reply({cmd, red, green, blue}));
			if (!in_valid || in_ready) begin
				if (request_queue.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
					nxt = request_queue.pop_front();
					{cmd, red, green, blue} <= nxt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch_replies
		led_reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_replies.size() == 0) begin
					$error("result with no request outstanding: compare_value %0d", compare_value);
					errors++;
				end else begin
					want = awaited_replies.pop_front();
					check_field("compare_value", want.compare, compare_value);
					check_field("accepted", 16'(want.accept), 16'(accepted));
					check_field("frame_last", 16'(want.last), 16'(frame_last));
					check_field("busy_res", 16'(want.busy), 16'(busy_res));
				end
			end
			out_ready <= steady || ($urandom_range(99) >= 34);
		end
	end

	task automatic push_request(logic [2:0] op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		request_queue.push_back({op, r, g, b});
	endtask

	function automatic logic [7:0] random_level();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return 8'h00;
		if (roll == 1)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	function automatic led_request_t random_request();
		led_request_t rq;
		int           roll;
		roll = $urandom_range(99);
		rq.r = random_level();
		rq.g = random_level();
		rq.b = random_level();
		if (roll < 55)
			rq.op = CMD_SLOT;
		else if (roll < 78)
			rq.op = CMD_TICK;
		else if (roll < 86)
			rq.op = CMD_SET;
		else if (roll < 92)
			rq.op = CMD_BREATHE;
		else if (roll < 96)
			rq.op = CMD_STOP;
		else
			rq.op = 3'($urandom_range(7, int'(CMD_STOP) + 1));
		return rq;
	endfunction

	task automatic wait_until_idle();
		while (request_queue.size() != 0 || in_valid || awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int count);
		repeat (count)
			request_queue.push_back(random_request());
		wait_until_idle();
	endtask

	task automatic write_register(reg_index_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_ONE_CODE:   mark_one = value;
			REG_ZERO_CODE:  mark_zero = value;
			REG_RESET_SLOT: gap_slots = value[7:0];
			REG_INTERVAL:   step_ticks = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		wait (arst_n);
		@(posedge clk);

		// Directed: the pending green frame, unknown and ignored commands, and breathing.
		push_request(CMD_SLOT, 8'h00, 8'h00, 8'h00);
		push_request(CMD_SLOT, 8'hFF, 8'hFF, 8'hFF);
		push_request(CMD_TICK, 8'h00, 8'h00, 8'h00);
		for (int op = int'(CMD_STOP) + 1; op < 8; op++)
			push_request(3'(op), 8'hFF, 8'h00, 8'hFF);
		push_request(CMD_SET, 8'hFF, 8'h00, 8'hFF);
		push_request(CMD_SLOT, 8'h00, 8'h00, 8'h00);
		push_request(CMD_SLOT, 8'h00, 8'h00, 8'h00);
		push_request(CMD_SET, 8'h00, 8'h00, 8'h00);
		push_request(CMD_SET, 8'hFF, 8'hFF, 8'hFF);
		push_request(CMD_SLOT, 8'h00, 8'h00, 8'h00);
		push_request(CMD_BREATHE, 8'h80, 8'hFF, 8'h01);
		push_request(CMD_BREATHE, 8'h11, 8'h22, 8'h33);
		push_request(CMD_SET, 8'h12, 8'h34, 8'h56);
		push_request(CMD_TICK, 8'h00, 8'h00, 8'h00);
		push_request(CMD_TICK, 8'h00, 8'h00, 8'h00);
		push_request(CMD_STOP, 8'hFF, 8'hFF, 8'hFF);
		push_request(CMD_SLOT, 8'h00, 8'h00, 8'h00);
		wait_until_idle();

		// An interval of zero steps the brightness on every tick.
		write_register(REG_ONE_CODE, 16'hFFFF);
		write_register(REG_ZERO_CODE, 16'h0000);
		write_register(REG_RESET_SLOT, 16'd0);
		write_register(REG_INTERVAL, 16'd0);
		run_random(350);

		steady = 1'b1;
		write_register(REG_ONE_CODE, 16'($urandom_range(65535)));
		write_register(REG_ZERO_CODE, 16'($urandom_range(65535)));
		write_register(REG_RESET_SLOT, 16'd255);
		write_register(REG_INTERVAL, 16'd1);
		run_random(300);
		push_request(CMD_STOP, 8'h00, 8'h00, 8'h00);
		repeat (60)
			push_request(CMD_SLOT, 8'h00, 8'h00, 8'h00);
		wait_until_idle();
		steady = 1'b0;

		// The frame in flight is now past its new end and must close on the next slot.
		write_register(REG_RESET_SLOT, 16'd0);
		write_register(REG_ONE_CODE, 16'h0000);
		write_register(REG_ZERO_CODE, 16'hFFFF);
		write_register(REG_INTERVAL, 16'hFFFF);
		push_request(CMD_SLOT, 8'h00, 8'h00, 8'h00);
		run_random(300);

		write_register(REG_ONE_CODE, 16'($urandom_range(65535)));
		write_register(REG_ZERO_CODE, 16'($urandom_range(65535)));
		write_register(REG_RESET_SLOT, 16'($urandom_range(8, 1)));
		write_register(REG_INTERVAL, 16'd2);
		run_random(350);

		repeat (10) @(posedge clk);
		if (awaited_replies.size() != 0) begin
			$error("%0d results never arrived", awaited_replies.size());
			errors++;
		end
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
